FILE: sv/lss_pkg.sv
// lss_pkg: shared types and constants for the lifo stack with search
// no dependencies

package lss_pkg;

   // default number of stack entries
   localparam int unsigned DEPTH_DEF = 128;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned COUNT_W   = 8;

   // request operation codes
   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_TOP    = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_POPRD,
      S_SRCH
   } state_type;

   // finished result handed from sequencer to the output stage
   typedef struct packed {
      logic                      done;
      logic signed [WORD_W-1:0]  top_value;
      logic                      found;
      logic [COUNT_W-1:0]        held_count;
      logic                      empty;
      status_type                status;
   } result_type;

endpackage

FILE: sv/lss_ram.sv
// lss_ram: generic single write port, single read port ram with registered read
// no dependencies

module lss_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/lss_seq.sv
// lss_seq: request sequencer, fill count, top register and search walk
// depends on lss_pkg; drives the ports of one lss_ram

module lss_seq #(
   parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [1:0]                          req_operation,
   input  logic signed [lss_pkg::WORD_W-1:0]   req_value,
   output logic                                busy,
   output logic                                ram_we,
   output logic [$clog2(DEPTH)-1:0]            ram_waddr,
   output logic [lss_pkg::WORD_W-1:0]          ram_wdata,
   output logic                                ram_re,
   output logic [$clog2(DEPTH)-1:0]            ram_raddr,
   input  logic [lss_pkg::WORD_W-1:0]          ram_rdata,
   output lss_pkg::result_type                 result
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   lss_pkg::state_type                 state_ff, state_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [CW-1:0]                      idx_ff, idx_in;
   logic                               last_ff, last_in;
   logic signed [lss_pkg::WORD_W-1:0]  top_ff, top_in;
   logic [lss_pkg::WORD_W-1:0]         key_ff, key_in;
   logic                               full, empty_now, hit;
   lss_pkg::op_type                    op;

   assign op        = lss_pkg::op_type'(req_operation);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty_now = (count_ff == '0);
   // shared compare unit, one stored entry per cycle
   assign hit       = (ram_rdata == key_ff);

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lss_pkg::S_IDLE;
         count_ff <= '0;
         top_ff   <= '0;
         idx_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
         idx_ff   <= idx_in;
         last_ff  <= last_in;
      end
   end

   // search key, payload only
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      key_in        = key_ff;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[AW-1:0];
      ram_wdata     = req_value;
      ram_re        = 1'b0;
      ram_raddr     = '0;
      result.done   = 1'b0;
      result.found  = 1'b0;
      result.status = lss_pkg::ST_OK;

      unique case (state_ff)
         lss_pkg::S_IDLE: begin
            if (start) begin
               unique case (op)
                  lss_pkg::OP_PUSH: begin
                     result.done = 1'b1;
                     if (full) begin
                        result.status = lss_pkg::ST_OVERFLOW;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                        top_in   = req_value;
                     end
                  end
                  lss_pkg::OP_POP: begin
                     if (empty_now) begin
                        result.done   = 1'b1;
                        result.status = lss_pkg::ST_UNDERFLOW;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (count_ff == CW'(1)) begin
                           top_in      = '0;
                           result.done = 1'b1;
                        end else begin
                           // fetch the entry below the old top
                           ram_re    = 1'b1;
                           ram_raddr = AW'(count_ff - CW'(2));
                           state_in  = lss_pkg::S_POPRD;
                        end
                     end
                  end
                  lss_pkg::OP_TOP: begin
                     result.done = 1'b1;
                     if (empty_now) begin
                        result.status = lss_pkg::ST_UNDERFLOW;
                     end
                  end
                  lss_pkg::OP_SEARCH: begin
                     if (empty_now) begin
                        result.done = 1'b1;
                     end else begin
                        // start the walk at the bottom entry
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        key_in    = req_value;
                        idx_in    = CW'(1);
                        last_in   = (count_ff == CW'(1));
                        state_in  = lss_pkg::S_SRCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         lss_pkg::S_POPRD: begin
            top_in      = ram_rdata;
            result.done = 1'b1;
            state_in    = lss_pkg::S_IDLE;
         end
         lss_pkg::S_SRCH: begin
            if (hit) begin
               result.done  = 1'b1;
               result.found = 1'b1;
               state_in     = lss_pkg::S_IDLE;
            end else if (last_ff) begin
               result.done = 1'b1;
               state_in    = lss_pkg::S_IDLE;
            end else begin
               // issue the next entry up while this one is compared
               ram_re    = 1'b1;
               ram_raddr = idx_ff[AW-1:0];
               idx_in    = idx_ff + CW'(1);
               last_in   = (idx_ff == count_ff - CW'(1));
            end
         end
         default: state_in = lss_pkg::S_IDLE;
      endcase

      result.top_value  = top_in;
      result.held_count = lss_pkg::COUNT_W'(count_in);
      result.empty      = (count_in == '0);
   end

   assign busy = (state_ff != lss_pkg::S_IDLE);

endmodule

FILE: sv/lifo_stack_with_search_top.sv
// lifo_stack_with_search_top: lifo stack of signed words with a value search
// depends on lss_pkg, lss_ram and lss_seq
//
// A request is taken when start is high and busy is low; its result shows on the rsp_ ports
// for exactly one cycle, marked by rsp_strobe, in the cycle after the request finishes, and
// the receiver cannot hold it off. Push, read top, a pop that empties the stack, any
// refused request (push when full, pop or read top when empty), and a search of an empty
// stack finish in the cycle that they are taken; a pop that leaves the stack non-empty
// goes through S_POPRD for the registered read of the new top entry; a search compares one
// held entry per cycle through the single ram read port, bottom up, and ends at the first
// match or after the last held entry. busy is high until the request finishes, and a new
// request may be taken in the same cycle that the previous result is shown. The entry store
// has no clearing pass and is usable right after reset.

module lifo_stack_with_search_top #(
   parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_operation,
   input  logic signed [lss_pkg::WORD_W-1:0]  req_value,
   output logic                               rsp_strobe,
   output logic signed [lss_pkg::WORD_W-1:0]  rsp_top_value,
   output logic                               rsp_found,
   output logic [lss_pkg::COUNT_W-1:0]        rsp_held_count,
   output logic                               rsp_empty_res,
   output logic [1:0]                         rsp_status
);

   localparam int unsigned AW = $clog2(DEPTH);

   logic                         ram_we, ram_re;
   logic [AW-1:0]                ram_waddr, ram_raddr;
   logic [lss_pkg::WORD_W-1:0]   ram_wdata, ram_rdata;
   lss_pkg::result_type          result;
   logic                         rsp_strobe_ff;
   lss_pkg::result_type          rsp_ff;

   // request sequencer
   lss_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .req_value     (req_value),
      .busy          (busy),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .result        (result)
   );

   // entry store
   lss_ram #(
      .WIDTH (lss_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= result.done;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_top_value  = rsp_ff.top_value;
   assign rsp_found      = rsp_ff.found;
   assign rsp_held_count = rsp_ff.held_count;
   assign rsp_empty_res  = rsp_ff.empty;
   assign rsp_status     = rsp_ff.status;

endmodule

FILE: sv/lss_chk.sv
// lss_chk: port-level checks for the lifo stack with search, bound to the top level
// depends on lss_pkg and lifo_stack_with_search_top

module lss_chk (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               rsp_strobe,
   input  logic signed [lss_pkg::WORD_W-1:0]  rsp_top_value,
   input  logic                               rsp_found,
   input  logic [lss_pkg::COUNT_W-1:0]        rsp_held_count,
   input  logic                               rsp_empty_res,
   input  logic [1:0]                         rsp_status
);

   // a taken request either finishes at once or holds busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("request neither answered nor busy");

   // no result without a request in flight
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !rsp_strobe)
      else $error("result without request");

   // result only once the sequencer has gone idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result while busy");

   // an empty stack shows zero top and zero count
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_empty_res) |-> (rsp_top_value == '0 && rsp_held_count == '0))
      else $error("empty result with nonzero top or count");

   // underflow only on an empty stack, never with a search hit
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == lss_pkg::ST_UNDERFLOW) |-> (rsp_empty_res && !rsp_found))
      else $error("underflow on non-empty stack");

endmodule

bind lifo_stack_with_search_top lss_chk u_lss_chk (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_top_value  (rsp_top_value),
   .rsp_found      (rsp_found),
   .rsp_held_count (rsp_held_count),
   .rsp_empty_res  (rsp_empty_res),
   .rsp_status     (rsp_status)
);
